### hw/rtl/rra_pkg.sv
`timescale 1ns / 1ps

package rra_pkg;

	// Coordinate width of pixels, window sizes and origins.
	localparam int COORD_BITS = 12;
	localparam int RADIUS_BITS = COORD_BITS - 1;

	// Squared half-pixel distance, scaled by 2^14 so the root carries 8 fraction bits.
	localparam int SUM_W = 2 * COORD_BITS + 1;
	localparam int SQRT_SHIFT = 14;
	localparam int ROOT_W = (SUM_W + SQRT_SHIFT + 1) / 2;
	localparam int OPND_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int DIST_W = ROOT_W + 2;

	// Edges from an accepted word to its result strobe being sampled.
	localparam int PIPE_LAT = ROOT_W + 4;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECT_WIDTH    = 3'd0,
		REG_RECT_HEIGHT   = 3'd1,
		REG_CORNER_RADIUS = 3'd2,
		REG_SIDE_MASK     = 3'd3,
		REG_INVERT_MODE   = 3'd4,
		REG_ORIGIN_X      = 3'd5,
		REG_ORIGIN_Y      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic       in_window;
	} result_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]  rect_width;
		logic [COORD_BITS-1:0]  rect_height;
		logic [RADIUS_BITS-1:0] corner_radius;
		logic [3:0]             side_mask;
		logic                   invert_mode;
		logic [COORD_BITS-1:0]  origin_x;
		logic [COORD_BITS-1:0]  origin_y;
	} cfg_t;

	// One slot of the square root chain.
	typedef struct packed {
		logic              valid;
		logic              in_win;
		logic              zone;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [OPND_W-1:0] opnd;
	} cell_t;

endpackage

### hw/rtl/rra_front.sv
`timescale 1ns / 1ps

module rra_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  rra_pkg::pixel_t      pixel,
	input  rra_pkg::cfg_t        cfg,
	output rra_pkg::cell_t       cell_out
);

	localparam int CB = rra_pkg::COORD_BITS;

	// Stage 1: window test and window-relative offsets.
	logic          valid_s1, in_win_s1;
	logic [CB-1:0] x_s1, y_s1;
	logic [CB:0]   end_x, end_y;
	logic          win_hit;

	always_comb begin
		end_x = {1'b0, cfg.origin_x} + {1'b0, cfg.rect_width};
		end_y = {1'b0, cfg.origin_y} + {1'b0, cfg.rect_height};
		win_hit = (pixel.pixel_x >= cfg.origin_x) && ({1'b0, pixel.pixel_x} < end_x) &&
			(pixel.pixel_y >= cfg.origin_y) && ({1'b0, pixel.pixel_y} < end_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			in_win_s1 <= 1'b0;
			x_s1 <= '0;
			y_s1 <= '0;
		end else begin
			valid_s1 <= in_valid;
			in_win_s1 <= win_hit;
			x_s1 <= pixel.pixel_x - cfg.origin_x;
			y_s1 <= pixel.pixel_y - cfg.origin_y;
		end
	end

	// Stage 2: corner zone and absolute half-pixel deltas (always odd).
	logic          valid_s2, in_win_s2, zone_s2;
	logic [CB-1:0] ax_s2, ay_s2;
	logic [CB-1:0] r_ext, tx, ty;
	logic          left, right, top, bottom;

	always_comb begin
		r_ext = {1'b0, cfg.corner_radius};
		left = cfg.side_mask[0] && (x_s1 < r_ext);
		right = cfg.side_mask[1] && (({1'b0, x_s1} + {1'b0, r_ext}) >= {1'b0, cfg.rect_width});
		top = cfg.side_mask[2] && (y_s1 < r_ext);
		bottom = cfg.side_mask[3] && (({1'b0, y_s1} + {1'b0, r_ext}) >= {1'b0, cfg.rect_height});
		tx = (x_s1 < r_ext) ? (r_ext - x_s1 - CB'(1)) : (x_s1 + r_ext - cfg.rect_width);
		ty = (y_s1 < r_ext) ? (r_ext - y_s1 - CB'(1)) : (y_s1 + r_ext - cfg.rect_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			in_win_s2 <= 1'b0;
			zone_s2 <= 1'b0;
			ax_s2 <= '0;
			ay_s2 <= '0;
		end else begin
			valid_s2 <= valid_s1;
			in_win_s2 <= in_win_s1;
			zone_s2 <= (left || right) && (top || bottom);
			ax_s2 <= {tx[CB-2:0], 1'b1};
			ay_s2 <= {ty[CB-2:0], 1'b1};
		end
	end

	// Stage 3: sum of squares, scaled into the root operand.
	logic [2*CB-1:0]               sq_x, sq_y;
	logic [rra_pkg::SUM_W-1:0]     sum;
	logic [rra_pkg::OPND_W-1:0]    opnd;

	always_comb begin
		sq_x = ax_s2 * ax_s2;
		sq_y = ay_s2 * ay_s2;
		sum = {1'b0, sq_x} + {1'b0, sq_y};
		opnd = {{(rra_pkg::OPND_W - rra_pkg::SUM_W - rra_pkg::SQRT_SHIFT){1'b0}}, sum,
			{rra_pkg::SQRT_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out <= '0;
		end else begin
			cell_out.valid <= valid_s2;
			cell_out.in_win <= in_win_s2;
			cell_out.zone <= zone_s2;
			cell_out.rem <= '0;
			cell_out.root <= '0;
			cell_out.opnd <= opnd;
		end
	end

endmodule

### hw/rtl/rra_sqrt_cell.sv
`timescale 1ns / 1ps

// One root bit per cell: restoring square root step on the top operand pair.
module rra_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  rra_pkg::cell_t d,
	output rra_pkg::cell_t q
);

	localparam int RW = rra_pkg::REM_W;
	localparam int TW = rra_pkg::ROOT_W;
	localparam int OW = rra_pkg::OPND_W;

	logic [RW+1:0] cur, trial, diff;
	logic          fit;

	always_comb begin
		cur = {d.rem, d.opnd[OW-1 -: 2]};
		trial = {{(RW - TW){1'b0}}, d.root, 2'b01};
		diff = cur - trial;
		fit = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q.valid <= d.valid;
			q.in_win <= d.in_win;
			q.zone <= d.zone;
			q.rem <= fit ? diff[RW-1:0] : cur[RW-1:0];
			q.root <= {d.root[TW-2:0], fit};
			q.opnd <= {d.opnd[OW-3:0], 2'b00};
		end
	end

endmodule

### hw/rtl/rra_back.sv
`timescale 1ns / 1ps

module rra_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rra_pkg::cell_t       d,
	input  rra_pkg::cfg_t        cfg,
	output logic                 result_valid,
	output rra_pkg::result_t     result
);

	localparam int DW = rra_pkg::DIST_W;

	logic [DW-1:0]        offset;
	logic signed [DW-1:0] arc_dist;
	logic [7:0]           v8, cov, alpha;
	logic [15:0]          prod;

	always_comb begin
		// Arc reference (2r - 1) * 128 in 1/256 pixel units.
		offset = DW'({cfg.corner_radius, 8'd0}) - DW'(128);
		arc_dist = $signed(DW'(d.root)) - $signed(offset);
		v8 = 8'd0 - arc_dist[7:0];
		prod = {v8, 8'd0} - {8'd0, v8};
		if (arc_dist[DW-1] || arc_dist == '0) begin
			cov = 8'hFF;
		end else if (|arc_dist[DW-2:8]) begin
			cov = 8'h00;
		end else begin
			cov = prod[15:8];
		end
		if (!d.in_win) begin
			alpha = 8'h00;
		end else if (!d.zone) begin
			alpha = cfg.invert_mode ? 8'h00 : 8'hFF;
		end else begin
			alpha = cfg.invert_mode ? ~cov : cov;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			result_valid <= d.valid;
			result.alpha <= alpha;
			result.in_window <= d.in_win;
		end
	end

endmodule

### hw/rtl/rounded_rect_alpha_mask.sv
`timescale 1ns / 1ps

// Antialiased rounded-rectangle coverage. Each word on pixel is an absolute
// pixel coordinate; the block answers its coverage byte alpha and in_window.
// The block never stalls: busy stays low, a new word may be started every
// clock, and every word gives exactly one result, in order, on result while
// result_valid is high for one cycle. The receiver cannot hold results off,
// so it must take each result in the cycle it appears. A word passes through
// three front stages for the window test, the corner deltas and the sum of
// squares, ROOT_W square root cells that each settle one root bit, and one
// output stage for the coverage byte. Configuration words are always taken
// (cfg_ready is high); write them only while no pixel is in flight, since
// late stages read the live registers.
module rounded_rect_alpha_mask (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  rra_pkg::pixel_t                      pixel,
	output logic                                 result_valid,
	output rra_pkg::result_t                     result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rra_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rra_pkg::COORD_BITS-1:0]       cfg_data
);

	localparam int CB = rra_pkg::COORD_BITS;
	localparam int RB = rra_pkg::RADIUS_BITS;

	// The pipeline takes a word every cycle, so there is never back-pressure.
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers, reset to a 16 by 16 window with radius 2 and
	// all four sides rounded.
	rra_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rect_width <= CB'(16);
			cfg_q.rect_height <= CB'(16);
			cfg_q.corner_radius <= RB'(2);
			cfg_q.side_mask <= 4'hF;
			cfg_q.invert_mode <= 1'b0;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rra_pkg::cfg_reg_t'(cfg_index))
				rra_pkg::REG_RECT_WIDTH: begin
					cfg_q.rect_width <= cfg_data;
				end
				rra_pkg::REG_RECT_HEIGHT: begin
					cfg_q.rect_height <= cfg_data;
				end
				rra_pkg::REG_CORNER_RADIUS: begin
					cfg_q.corner_radius <= cfg_data[RB-1:0];
				end
				rra_pkg::REG_SIDE_MASK: begin
					cfg_q.side_mask <= cfg_data[3:0];
				end
				rra_pkg::REG_INVERT_MODE: begin
					cfg_q.invert_mode <= cfg_data[0];
				end
				rra_pkg::REG_ORIGIN_X: begin
					cfg_q.origin_x <= cfg_data;
				end
				rra_pkg::REG_ORIGIN_Y: begin
					cfg_q.origin_y <= cfg_data;
				end
				default: begin
					// Indexes past the register list are dropped.
				end
			endcase
		end
	end

	// Front stages feed the square root chain.
	rra_pkg::cell_t chain [0:rra_pkg::ROOT_W];

	rra_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.pixel    (pixel),
		.cfg      (cfg_q),
		.cell_out (chain[0])
	);

	// One cell per root bit, most significant first. Each cell hands its
	// remainder, partial root and shifted operand to the next every cycle.
	for (genvar i = 0; i < rra_pkg::ROOT_W; i++) begin : g_cell
		rra_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// Distance to the arc and the coverage byte.
	rra_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.d            (chain[rra_pkg::ROOT_W]),
		.cfg          (cfg_q),
		.result_valid (result_valid),
		.result       (result)
	);

	// Every started word is followed by its result strobe.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(rra_pkg::PIPE_LAT) result_valid)
		else $error("result strobe missing for a started word");

	// No result strobe without a started word before it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, rra_pkg::PIPE_LAT))
		else $error("result strobe without a started word");

	// Pixels outside the window carry zero coverage.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.in_window) |-> (result.alpha == 8'h00))
		else $error("nonzero alpha outside the window");

	// Outside a corner zone the byte is full or empty, never in between,
	// when invert mode is off and the pixel lies in the window; stated here
	// on the corner-free case of a zero radius.
	a_no_radius_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.in_window && cfg_q.corner_radius == '0
			&& !cfg_q.invert_mode) |-> (result.alpha == 8'hFF))
		else $error("partial alpha with no corner radius");

endmodule
